// ----- src/fmpl_pkg.sv -----
package fmpl_pkg;

  localparam int CURRENT_CLAMP_DEF = 16000;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;
  localparam int MOTORS = 4;

  localparam logic [2:0] REG_MAX_POWER = 3'd0;
  localparam logic [2:0] REG_TORQUE_COEFF = 3'd1;
  localparam logic [2:0] REG_CURRENT_SQ_COEFF = 3'd2;
  localparam logic [2:0] REG_SPEED_SQ_COEFF = 3'd3;
  localparam logic [2:0] REG_STATIC_POWER = 3'd4;

  typedef logic signed [14:0] cur_t;
  typedef logic signed [15:0] spd_t;
  typedef logic signed [32:0] pw_t;

  typedef struct packed {
    logic [25:0] max_power;
    logic [31:0] torque_coeff;
    logic [31:0] current_sq_coeff;
    logic [31:0] speed_sq_coeff;
    logic [25:0] static_power;
  } cfg_t;

  typedef struct packed {
    cur_t [3:0]  cur;
    spd_t [3:0]  spd;
    pw_t [3:0]   pw;
    logic [35:0] total;
    logic        limited;
  } mid_t;

  typedef struct packed {
    cur_t [3:0] res;
    logic       was_limited;
  } out_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
    cur_t result;
  } lane_sts_t;

  typedef enum logic {
    B_IDLE,
    B_SOLVE
  } back_state_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_MUL0,
    L_MUL0B,
    L_DIV1,
    L_CCALC,
    L_MUL1,
    L_MUL2,
    L_MUL3,
    L_DISC,
    L_DISC2,
    L_SQRT,
    L_NUM,
    L_DIV2,
    L_FIN,
    L_DONE
  } lane_state_t;

endpackage

// ----- src/fmpl_fifo.sv -----
module fmpl_fifo #(
  parameter type word_t = logic,
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  word_t wdata,
  output logic  full,
  input  logic  pop,
  output word_t rdata,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  word_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ----- src/fmpl_front.sv -----
module fmpl_front (
  input  logic                clk,
  input  logic                rst,
  input  fmpl_pkg::cfg_t      cfg,
  input  logic                push,
  input  fmpl_pkg::cur_t [3:0] cur_in,
  input  fmpl_pkg::spd_t [3:0] spd_in,
  output logic                full,
  input  logic                mid_full,
  output logic                mid_push,
  output fmpl_pkg::mid_t      mid_word
);

  logic en;
  logic va, vb, vc, vd;

  fmpl_pkg::cur_t a_cur [4];
  fmpl_pkg::spd_t a_spd [4];
  fmpl_pkg::cur_t b_cur [4];
  fmpl_pkg::spd_t b_spd [4];
  fmpl_pkg::cur_t c_cur [4];
  fmpl_pkg::spd_t c_spd [4];
  fmpl_pkg::cur_t d_cur [4];
  fmpl_pkg::spd_t d_spd [4];
  logic signed [30:0] b_cs [4];
  logic [28:0] b_cc [4];
  logic [30:0] b_ss [4];
  logic signed [63:0] c_t1 [4];
  logic [63:0] c_t2 [4];
  logic [63:0] c_t3 [4];
  fmpl_pkg::pw_t d_pw [4];
  logic [64:0] sum [4];
  logic signed [36:0] total;

  assign en = !(vd && mid_full);
  assign full = !en;
  assign mid_push = vd && !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      va <= push;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = 65'(c_t1[i]) + 65'(c_t2[i]) + 65'(c_t3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a_cur[i] <= cur_in[i];
        a_spd[i] <= spd_in[i];
        b_cur[i] <= a_cur[i];
        b_spd[i] <= a_spd[i];
        b_cs[i] <= 31'(32'(a_cur[i]) * 32'(a_spd[i]));
        b_cc[i] <= 29'(30'(a_cur[i]) * 30'(a_cur[i]));
        b_ss[i] <= 31'(32'(a_spd[i]) * 32'(a_spd[i]));
        c_cur[i] <= b_cur[i];
        c_spd[i] <= b_spd[i];
        c_t1[i] <= 64'($signed({1'b0, cfg.torque_coeff})) * 64'(b_cs[i]);
        c_t2[i] <= 64'(cfg.current_sq_coeff) * 64'(b_cc[i]);
        c_t3[i] <= 64'(cfg.speed_sq_coeff) * 64'(b_ss[i]);
        d_cur[i] <= c_cur[i];
        d_spd[i] <= c_spd[i];
        d_pw[i] <= $signed(sum[i][64:32]);
      end
    end
  end

  always_comb begin
    total = $signed({11'd0, cfg.static_power}) + 37'(d_pw[0]) + 37'(d_pw[1])
            + 37'(d_pw[2]) + 37'(d_pw[3]);
    for (int i = 0; i < 4; i++) begin
      mid_word.cur[i] = d_cur[i];
      mid_word.spd[i] = d_spd[i];
      mid_word.pw[i] = d_pw[i];
    end
    mid_word.total = total[35:0];
    mid_word.limited = (total > $signed({11'd0, cfg.max_power}));
  end

endmodule

// ----- src/fmpl_lane.sv -----
module fmpl_lane #(
  parameter int CLAMP = fmpl_pkg::CURRENT_CLAMP_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fmpl_pkg::cfg_t        cfg,
  input  fmpl_pkg::lane_ctl_t   ctl,
  input  fmpl_pkg::pw_t         pw_in,
  input  fmpl_pkg::spd_t        spd_in,
  input  logic                  cur_pos_in,
  input  logic [35:0]           total_in,
  output fmpl_pkg::lane_sts_t   sts
);

  fmpl_pkg::lane_state_t st, st_next;

  fmpl_pkg::pw_t pw;
  fmpl_pkg::spd_t spd;
  logic cur_pos;
  logic [35:0] tot;
  logic signed [59:0] prod1;
  logic signed [48:0] b;
  logic [30:0] spdsq;
  logic [61:0] k2w2;
  logic neg1;
  logic [63:0] dvd;
  logic [37:0] rem;
  logic [37:0] dsor;
  logic [5:0] cnt;
  logic [63:0] c;
  logic [63:0] plo, phi;
  logic [47:0] bll, bhl, bhh;
  logic [97:0] ac4;
  logic [95:0] b2;
  logic [101:0] dsh;
  logic [53:0] sqrem;
  logic [50:0] root;
  logic numneg;
  fmpl_pkg::cur_t result;

  logic [31:0] a;
  logic [38:0] rsh;
  logic div_ge;
  logic [37:0] rem_step;
  logic [59:0] p1abs;
  logic signed [61:0] tt;
  logic [63:0] cabs;
  logic [47:0] babs;
  logic [95:0] ac;
  logic [98:0] dval;
  logic [55:0] srsh;
  logic [55:0] strial;
  logic sq_ge;
  logic signed [53:0] num;
  logic [53:0] numabs;
  logic [14:0] mag;

  assign a = (cfg.current_sq_coeff == '0) ? 32'd1 : cfg.current_sq_coeff;

  always_comb begin
    rsh = {rem, dvd[63]};
    div_ge = (rsh >= {1'b0, dsor});
    rem_step = div_ge ? 38'(rsh - {1'b0, dsor}) : rsh[37:0];
    p1abs = prod1[59] ? 60'(-prod1) : 60'(prod1);
    tt = (neg1 ? -$signed({3'b000, dvd[58:0]}) : $signed({3'b000, dvd[58:0]}))
         - $signed({36'd0, cfg.static_power});
    cabs = c[63] ? (64'd0 - c) : c;
    babs = b[48] ? 48'(-b) : 48'(b);
    ac = 96'(plo) + {phi, 32'd0};
    if (c[63] || (c == '0)) begin
      dval = 99'(b2) + 99'(ac4);
    end else if (ac4 <= 98'(b2)) begin
      dval = 99'(b2) - 99'(ac4);
    end else begin
      dval = '0;
    end
    srsh = {sqrem, dsh[101:100]};
    strial = 56'({root, 2'b01});
    sq_ge = (srsh >= strial);
    num = cur_pos ? ($signed({3'b000, root}) - 54'(b))
                  : (-54'(b) - $signed({3'b000, root}));
    numabs = num[53] ? 54'(-num) : 54'(num);
    mag = (dvd > 64'(CLAMP)) ? 15'(CLAMP) : dvd[14:0];
  end

  always_comb begin
    st_next = st;
    unique case (st)
      fmpl_pkg::L_IDLE:  if (ctl.start) st_next = fmpl_pkg::L_MUL0;
      fmpl_pkg::L_MUL0:  st_next = fmpl_pkg::L_MUL0B;
      fmpl_pkg::L_MUL0B: st_next = fmpl_pkg::L_DIV1;
      fmpl_pkg::L_DIV1:  if (cnt == 6'd63) st_next = fmpl_pkg::L_CCALC;
      fmpl_pkg::L_CCALC: st_next = fmpl_pkg::L_MUL1;
      fmpl_pkg::L_MUL1:  st_next = fmpl_pkg::L_MUL2;
      fmpl_pkg::L_MUL2:  st_next = fmpl_pkg::L_MUL3;
      fmpl_pkg::L_MUL3:  st_next = fmpl_pkg::L_DISC;
      fmpl_pkg::L_DISC:  st_next = fmpl_pkg::L_DISC2;
      fmpl_pkg::L_DISC2: st_next = fmpl_pkg::L_SQRT;
      fmpl_pkg::L_SQRT:  if (cnt == 6'd50) st_next = fmpl_pkg::L_NUM;
      fmpl_pkg::L_NUM:   st_next = fmpl_pkg::L_DIV2;
      fmpl_pkg::L_DIV2:  if (cnt == 6'd63) st_next = fmpl_pkg::L_FIN;
      fmpl_pkg::L_FIN:   st_next = fmpl_pkg::L_DONE;
      fmpl_pkg::L_DONE:  if (ctl.ack) st_next = fmpl_pkg::L_IDLE;
      default:           st_next = fmpl_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fmpl_pkg::L_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      fmpl_pkg::L_IDLE: begin
        pw <= pw_in;
        spd <= spd_in;
        cur_pos <= cur_pos_in;
        tot <= total_in;
      end
      fmpl_pkg::L_MUL0: begin
        prod1 <= 60'(pw) * 60'($signed({1'b0, cfg.max_power}));
        b <= 49'($signed({1'b0, cfg.torque_coeff})) * 49'(spd);
        spdsq <= 31'(32'(spd) * 32'(spd));
      end
      fmpl_pkg::L_MUL0B: begin
        k2w2 <= 62'(cfg.speed_sq_coeff) * 62'(spdsq);
        neg1 <= prod1[59];
        dvd <= 64'(p1abs);
        rem <= '0;
        dsor <= 38'(tot);
        cnt <= '0;
      end
      fmpl_pkg::L_DIV1, fmpl_pkg::L_DIV2: begin
        dvd <= {dvd[62:0], div_ge};
        rem <= rem_step;
        cnt <= cnt + 1'b1;
      end
      fmpl_pkg::L_CCALC: begin
        c <= 64'(k2w2) - {tt[31:0], 32'd0};
      end
      fmpl_pkg::L_MUL1: begin
        plo <= 64'(a) * 64'(cabs[31:0]);
        bll <= 48'(babs[23:0]) * 48'(babs[23:0]);
      end
      fmpl_pkg::L_MUL2: begin
        phi <= 64'(a) * 64'(cabs[63:32]);
        bhl <= 48'(babs[47:24]) * 48'(babs[23:0]);
      end
      fmpl_pkg::L_MUL3: begin
        bhh <= 48'(babs[47:24]) * 48'(babs[47:24]);
      end
      fmpl_pkg::L_DISC: begin
        ac4 <= {ac, 2'b00};
        b2 <= {bhh, 48'd0} + 96'({bhl, 25'd0}) + 96'(bll);
      end
      fmpl_pkg::L_DISC2: begin
        dsh <= 102'(dval);
        sqrem <= '0;
        root <= '0;
        cnt <= '0;
      end
      fmpl_pkg::L_SQRT: begin
        sqrem <= sq_ge ? 54'(srsh - strial) : srsh[53:0];
        root <= {root[49:0], sq_ge};
        dsh <= {dsh[99:0], 2'b00};
        cnt <= cnt + 1'b1;
      end
      fmpl_pkg::L_NUM: begin
        numneg <= num[53];
        dvd <= 64'(numabs);
        rem <= '0;
        dsor <= 38'({a, 1'b0});
        cnt <= '0;
      end
      fmpl_pkg::L_FIN: begin
        result <= numneg ? $signed(15'd0 - mag) : $signed(mag);
      end
      default: begin
      end
    endcase
  end

  assign sts.done = (st == fmpl_pkg::L_DONE);
  assign sts.result = result;

endmodule

// ----- src/fmpl_back.sv -----
module fmpl_back #(
  parameter int CLAMP = fmpl_pkg::CURRENT_CLAMP_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  fmpl_pkg::cfg_t cfg,
  input  logic           mid_empty,
  input  fmpl_pkg::mid_t mid_word,
  output logic           mid_pop,
  input  logic           out_full,
  output logic           out_push,
  output fmpl_pkg::out_t out_word
);

  fmpl_pkg::back_state_t st, st_next;
  fmpl_pkg::lane_ctl_t ctl;
  fmpl_pkg::lane_sts_t sts [fmpl_pkg::MOTORS];
  logic all_done;

  for (genvar g = 0; g < fmpl_pkg::MOTORS; g++) begin : g_lane
    fmpl_lane #(
      .CLAMP(CLAMP)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .ctl       (ctl),
      .pw_in     (mid_word.pw[g]),
      .spd_in    (mid_word.spd[g]),
      .cur_pos_in(mid_word.cur[g] > 0),
      .total_in  (mid_word.total),
      .sts       (sts[g])
    );
  end

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < fmpl_pkg::MOTORS; i++) begin
      all_done = all_done && sts[i].done;
    end
  end

  always_comb begin
    st_next = st;
    mid_pop = 1'b0;
    out_push = 1'b0;
    ctl.start = 1'b0;
    ctl.ack = 1'b0;
    out_word.res = mid_word.cur;
    out_word.was_limited = 1'b0;
    unique case (st)
      fmpl_pkg::B_IDLE: begin
        if (!mid_empty) begin
          if (!mid_word.limited) begin
            if (!out_full) begin
              out_push = 1'b1;
              mid_pop = 1'b1;
            end
          end else begin
            mid_pop = 1'b1;
            ctl.start = 1'b1;
            st_next = fmpl_pkg::B_SOLVE;
          end
        end
      end
      fmpl_pkg::B_SOLVE: begin
        for (int i = 0; i < fmpl_pkg::MOTORS; i++) begin
          out_word.res[i] = sts[i].result;
        end
        out_word.was_limited = 1'b1;
        if (all_done && !out_full) begin
          out_push = 1'b1;
          ctl.ack = 1'b1;
          st_next = fmpl_pkg::B_IDLE;
        end
      end
      default: st_next = fmpl_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fmpl_pkg::B_IDLE;
    end else begin
      st <= st_next;
    end
  end

endmodule

// ----- src/four_motor_power_limiter.sv -----
// Four-motor power limiter.
// Input words (four current commands, four speeds) are pushed while full is low.
// Result words (four limited currents and a limited flag) wait in an output queue
// and are taken with pop while empty is low; results leave in input order.
// Configuration registers are written through write_enable, write_index and
// write_data at any clock edge; indexes beyond the register list are ignored.
// A four-stage front pipeline estimates each motor's power and the total, and
// accepts one word per cycle while the middle queue has room.
// A word at or under the ceiling goes through the front stages and both queues;
// the back end handles one such word per cycle while the output queue has room.
// A word over the ceiling goes to four parallel solver lanes, one per motor,
// each running a serial divide, a serial square root and a second serial
// divide; the back end takes no new word until all four lanes are done.
// When the receiver stalls, the output queue fills, the back end holds, the
// middle queue fills and full rises; nothing is lost.
// Reset empties all queues and restores the register reset values.
module four_motor_power_limiter #(
  parameter int CURRENT_CLAMP = fmpl_pkg::CURRENT_CLAMP_DEF,
  parameter int MID_DEPTH = fmpl_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = fmpl_pkg::OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [14:0] current_0,
  input  logic signed [14:0] current_1,
  input  logic signed [14:0] current_2,
  input  logic signed [14:0] current_3,
  input  logic signed [15:0] speed_0,
  input  logic signed [15:0] speed_1,
  input  logic signed [15:0] speed_2,
  input  logic signed [15:0] speed_3,
  output logic               empty,
  input  logic               pop,
  output logic signed [14:0] limited_current_0,
  output logic signed [14:0] limited_current_1,
  output logic signed [14:0] limited_current_2,
  output logic signed [14:0] limited_current_3,
  output logic               was_limited,
  input  logic               write_enable,
  input  logic [2:0]         write_index,
  input  logic [31:0]        write_data
);

  fmpl_pkg::cfg_t cfg;
  fmpl_pkg::cur_t [3:0] cur_in;
  fmpl_pkg::spd_t [3:0] spd_in;
  fmpl_pkg::mid_t mid_in, mid_out;
  fmpl_pkg::out_t out_in, out_out;
  logic mid_push, mid_full, mid_pop, mid_empty;
  logic out_push, out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_power <= 26'd17039360;
      cfg.torque_coeff <= '0;
      cfg.current_sq_coeff <= 32'd54043195;
      cfg.speed_sq_coeff <= '0;
      cfg.static_power <= '0;
    end else if (write_enable) begin
      case (write_index)
        fmpl_pkg::REG_MAX_POWER:        cfg.max_power <= write_data[25:0];
        fmpl_pkg::REG_TORQUE_COEFF:     cfg.torque_coeff <= write_data;
        fmpl_pkg::REG_CURRENT_SQ_COEFF: cfg.current_sq_coeff <= write_data;
        fmpl_pkg::REG_SPEED_SQ_COEFF:   cfg.speed_sq_coeff <= write_data;
        fmpl_pkg::REG_STATIC_POWER:     cfg.static_power <= write_data[25:0];
        default: begin
        end
      endcase
    end
  end

  assign cur_in = {current_3, current_2, current_1, current_0};
  assign spd_in = {speed_3, speed_2, speed_1, speed_0};

  fmpl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .cur_in  (cur_in),
    .spd_in  (spd_in),
    .full    (full),
    .mid_full(mid_full),
    .mid_push(mid_push),
    .mid_word(mid_in)
  );

  fmpl_fifo #(
    .word_t(fmpl_pkg::mid_t),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .wdata(mid_in),
    .full (mid_full),
    .pop  (mid_pop),
    .rdata(mid_out),
    .empty(mid_empty)
  );

  fmpl_back #(
    .CLAMP(CURRENT_CLAMP)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_empty(mid_empty),
    .mid_word (mid_out),
    .mid_pop  (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_word (out_in)
  );

  fmpl_fifo #(
    .word_t(fmpl_pkg::out_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .wdata(out_in),
    .full (out_full),
    .pop  (pop),
    .rdata(out_out),
    .empty(empty)
  );

  assign limited_current_0 = out_out.res[0];
  assign limited_current_1 = out_out.res[1];
  assign limited_current_2 = out_out.res[2];
  assign limited_current_3 = out_out.res[3];
  assign was_limited = out_out.was_limited;

endmodule

// ----- tb/power_limit_checker.sv -----
`timescale 1ns / 100ps

module power_limit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  fmpl_pkg::cur_t     current_0,
  input  fmpl_pkg::cur_t     current_1,
  input  fmpl_pkg::cur_t     current_2,
  input  fmpl_pkg::cur_t     current_3,
  input  fmpl_pkg::spd_t     speed_0,
  input  fmpl_pkg::spd_t     speed_1,
  input  fmpl_pkg::spd_t     speed_2,
  input  fmpl_pkg::spd_t     speed_3,
  input  logic               empty,
  input  logic               pop,
  input  fmpl_pkg::cur_t     limited_current_0,
  input  fmpl_pkg::cur_t     limited_current_1,
  input  fmpl_pkg::cur_t     limited_current_2,
  input  fmpl_pkg::cur_t     limited_current_3,
  input  logic               was_limited,
  input  logic               write_enable,
  input  logic [2:0]         write_index,
  input  logic [31:0]        write_data,
  output int                 errors,
  output int                 pending
);
  import fmpl_pkg::*;

  localparam logic signed [127:0] TWO_POW_32 = 128'sd4294967296;
  localparam logic signed [127:0] CLAMP = CURRENT_CLAMP_DEF;

  logic [25:0] max_power;
  logic [31:0] torque_coeff;
  logic [31:0] current_sq_coeff;
  logic [31:0] speed_sq_coeff;
  logic [25:0] static_power;

  out_t expected_currents[$];

  assign pending = expected_currents.size();

  function automatic out_t limit_currents(input cur_t cur[4], input spd_t spd[4]);
    logic signed [127:0] kt, k1, k2, st, mx, a, ci, si, total, scaled, b, c, d, t, root, num, res;
    logic signed [127:0] pw[4];
    out_t r;
    kt = torque_coeff;
    k1 = current_sq_coeff;
    k2 = speed_sq_coeff;
    st = static_power;
    mx = max_power;
    total = st;
    for (int i = 0; i < 4; i++) begin
      ci = cur[i];
      si = spd[i];
      pw[i] = (kt * ci * si + k1 * ci * ci + k2 * si * si) >>> 32;
      total = total + pw[i];
    end
    r.was_limited = total > mx;
    for (int i = 0; i < 4; i++) begin
      if (!r.was_limited) begin
        r.res[i] = cur[i];
      end else begin
        ci = cur[i];
        si = spd[i];
        a = (k1 == 0) ? 128'sd1 : k1;
        scaled = (pw[i] * mx) / total;
        b = kt * si;
        c = k2 * si * si - (scaled - st) * TWO_POW_32;
        d = b * b - 128'sd4 * a * c;
        if (d < 0) d = 0;
        root = 0;
        for (int k = 50; k >= 0; k--) begin
          t = root | (128'sd1 <<< k);
          if (t * t <= d) root = t;
        end
        num = (ci > 0) ? -b + root : -b - root;
        res = num / (128'sd2 * a);
        if (res > CLAMP) res = CLAMP;
        if (res < -CLAMP) res = -CLAMP;
        r.res[i] = cur_t'(res);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cur_t cur[4];
    spd_t spd[4];
    out_t got, want;
    if (rst) begin
      max_power <= 26'd17039360;
      torque_coeff <= '0;
      current_sq_coeff <= 32'd54043195;
      speed_sq_coeff <= '0;
      static_power <= '0;
      expected_currents.delete();
      errors <= 0;
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_MAX_POWER: max_power <= write_data[25:0];
          REG_TORQUE_COEFF: torque_coeff <= write_data;
          REG_CURRENT_SQ_COEFF: current_sq_coeff <= write_data;
          REG_SPEED_SQ_COEFF: speed_sq_coeff <= write_data;
          REG_STATIC_POWER: static_power <= write_data[25:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        cur = '{current_0, current_1, current_2, current_3};
        spd = '{speed_0, speed_1, speed_2, speed_3};
        expected_currents.push_back(limit_currents(cur, spd));
      end
      if (pop && !empty) begin
        got.res[0] = limited_current_0;
        got.res[1] = limited_current_1;
        got.res[2] = limited_current_2;
        got.res[3] = limited_current_3;
        got.was_limited = was_limited;
        if (expected_currents.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_currents.pop_front();
          if (want != got) begin
            for (int i = 0; i < 4; i++)
              if (want.res[i] != got.res[i])
                $display("%0t: limited_current_%0d expected %0d actual %0d",
                         $time, i, want.res[i], got.res[i]);
            if (want.was_limited != got.was_limited)
              $display("%0t: was_limited expected %0b actual %0b",
                       $time, want.was_limited, got.was_limited);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/four_motor_power_limiter_tb.sv -----
`timescale 1ns / 100ps

module four_motor_power_limiter_tb;
  import fmpl_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, was_limited;
  cur_t current_0 = '0, current_1 = '0, current_2 = '0, current_3 = '0;
  spd_t speed_0 = '0, speed_1 = '0, speed_2 = '0, speed_3 = '0;
  cur_t limited_current_0, limited_current_1, limited_current_2, limited_current_3;
  logic write_enable = 1'b0;
  logic [2:0] write_index = '0;
  logic [31:0] write_data = '0;
  int errors, pending;
  int send_gap_max = 9;
  int take_gap_max = 9;
  int words_taken = 0;

  always #10 clk = ~clk;

  four_motor_power_limiter uut (.*);

  power_limit_checker checker_i (.*);

  task automatic send_word(input cur_t c0, c1, c2, c3, input spd_t s0, s1, s2, s3);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    current_0 <= c0;
    current_1 <= c1;
    current_2 <= c2;
    current_3 <= c3;
    speed_0 <= s0;
    speed_1 <= s1;
    speed_2 <= s2;
    speed_3 <= s3;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic cur_t pick_current(input int mode);
    case (mode)
      0: return cur_t'($urandom);
      1: return cur_t'($urandom_range(0, 400) - 200);
      2: case ($urandom_range(0, 3))
           0: return cur_t'(-16384);
           1: return cur_t'(16383);
           2: return cur_t'(0);
           default: return cur_t'(-1);
         endcase
      default: return cur_t'($urandom_range(0, 32000) - 16000);
    endcase
  endfunction

  function automatic spd_t pick_speed(input int mode);
    case (mode)
      0: return spd_t'($urandom);
      1: return spd_t'($urandom_range(0, 2000) - 1000);
      2: case ($urandom_range(0, 2))
           0: return spd_t'(-32768);
           1: return spd_t'(32767);
           default: return spd_t'(0);
         endcase
      default: return spd_t'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  function automatic logic [31:0] pick_setting(input logic [31:0] top_value);
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return top_value;
      2: return $urandom & top_value;
      default: return ($urandom & top_value) >> $urandom_range(4, 24);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic send_random(input int count);
    int mode;
    repeat (count) begin
      mode = $urandom_range(0, 3);
      send_word(pick_current(mode), pick_current(mode), pick_current(mode),
                pick_current(mode), pick_speed(mode), pick_speed(mode),
                pick_speed(mode), pick_speed(mode));
    end
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(0, 0, 0, 0, 0, 0, 0, 0);
    send_word(16383, 16383, 16383, 16383, 0, 0, 0, 0);
    send_word(-16384, -16384, -16384, -16384, 0, 0, 0, 0);
    send_word(16000, -16000, 16000, -16000, 32767, -32768, 32767, -32768);
    send_word(1, -1, 0, 16383, -1, 1, 0, 32767);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_TORQUE_COEFF, 32'd40000000);
    write_reg(REG_SPEED_SQ_COEFF, 32'd200);
    send_word(16383, 16383, 16383, 16383, 32767, 32767, 32767, 32767);
    send_word(-16384, 16383, 0, -16384, 32767, -32768, 32767, 32767);
    send_word(16383, -16384, 16383, -16384, -32768, 32767, 0, 0);
    send_word(0, 0, 0, 0, 32767, -32768, 32767, -32768);
    send_word(-300, 300, 16383, 16383, 32767, -32768, 32767, 32767);
    send_word(8000, -8000, 100, -100, -20000, 20000, -30000, 30000);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_CURRENT_SQ_COEFF, 32'd0);
    write_reg(REG_STATIC_POWER, 32'd5000000);
    send_word(16383, -16384, 1, -1, 32767, -32768, 30000, -30000);
    send_word(0, 0, 0, 0, 0, 0, 0, 0);
    send_word(-16384, 16383, -16384, 16383, -32768, 32767, 32767, -32768);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_MAX_POWER, 32'd0);
    send_word(100, -100, 0, 5, 10, -10, 0, 3);
    send_word(0, 0, 0, 0, 0, 0, 0, 0);
    send_random(140);

    for (int phase = 1; phase <= 7; phase++) begin
      send_gap_max = (phase % 3 == 2) ? 0 : 9;
      take_gap_max = (phase % 3 == 0) ? 0 : 9;
      case (phase)
        1: begin
          write_reg(REG_MAX_POWER, 32'h03FF_FFFF);
          write_reg(REG_TORQUE_COEFF, 32'hFFFF_FFFF);
          write_reg(REG_CURRENT_SQ_COEFF, 32'hFFFF_FFFF);
          write_reg(REG_SPEED_SQ_COEFF, 32'hFFFF_FFFF);
          write_reg(REG_STATIC_POWER, 32'h03FF_FFFF);
          write_reg(3'd5, 32'hFFFF_FFFF);
          write_reg(3'd7, 32'd0);
        end
        2: begin
          write_reg(REG_MAX_POWER, 32'd17039360);
          write_reg(REG_TORQUE_COEFF, 32'd30000000);
          write_reg(REG_CURRENT_SQ_COEFF, 32'd54043195);
          write_reg(REG_SPEED_SQ_COEFF, 32'd100);
          write_reg(REG_STATIC_POWER, 32'd0);
        end
        default: begin
          write_reg(REG_MAX_POWER, pick_setting(32'h03FF_FFFF));
          write_reg(REG_TORQUE_COEFF, pick_setting(32'hFFFF_FFFF));
          write_reg(REG_CURRENT_SQ_COEFF, pick_setting(32'hFFFF_FFFF));
          write_reg(REG_SPEED_SQ_COEFF, pick_setting(32'h0000_FFFF));
          write_reg(REG_STATIC_POWER, pick_setting(32'h00FF_FFFF));
        end
      endcase
      send_random(130);
    end

    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("four_motor_power_limiter_tb passed");
    else
      $display("four_motor_power_limiter_tb failed");
    $finish;
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (words_taken == 250) begin
        pop <= 1'b0;
        repeat (2000) @(posedge clk);
      end
      gap = $urandom_range(0, take_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      words_taken++;
    end
  end

  initial begin
    #(20 * 4000000);
    $display("four_motor_power_limiter_tb failed");
    $finish;
  end

endmodule
